[design/sbq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sbq_pkg
// shared types, codes and sizes of the socket segment buffer queue
// ----------------------------------------------------------------------------
package sbq_pkg;

  localparam int unsigned SEGS       = 64;
  localparam int unsigned IDX_W      = $clog2(SEGS);
  localparam int unsigned CNT_W      = $clog2(SEGS + 1);
  localparam int unsigned MAX_RES    = 64;
  localparam int unsigned RES_W      = $clog2(MAX_RES + 1);
  localparam int unsigned LEN_W      = 20;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned SND_W      = 48;
  localparam int unsigned ACT_W      = 3;
  localparam int unsigned IN_DATA_W  = 160;
  localparam int unsigned OUT_DATA_W = 200;
  localparam int unsigned QDEPTH     = 2;
  localparam int unsigned QPTR_W     = $clog2(QDEPTH);
  localparam int unsigned QCNT_W     = $clog2(QDEPTH + 1);
  localparam logic [LEN_W-1:0] MAX_SIZE_RST = LEN_W'(4096);

  typedef enum logic [ACT_W-1:0] {
    ACT_APPEND = 3'd0,
    ACT_FETCH  = 3'd1,
    ACT_REMOVE = 3'd2,
    ACT_COPY   = 3'd3,
    ACT_QUERY  = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_BLOCK = 2'd1,
    STS_ERR   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    QK_USED = 2'd0,
    QK_FREE = 2'd1,
    QK_MAX  = 2'd2
  } qkind_e;

  typedef enum logic [2:0] {
    K_APPEND,
    K_FETCH_STREAM,
    K_FETCH_RECORD,
    K_REMOVE,
    K_COPY,
    K_QUERY,
    K_BAD
  } kind_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_FLUSH
  } state_e;

  typedef struct packed {
    kind_e              kind;
    logic [ADDR_W-1:0]  addr;
    logic [ADDR_W-1:0]  base;
    logic [LEN_W-1:0]   len;
    logic [SND_W-1:0]   sender;
    logic               atomic;
    logic               peek;
    logic               remove_all;
    logic [LEN_W-1:0]   offset;
    logic [1:0]         qkind;
    logic               stopped;
  } cmd_t;

  typedef struct packed {
    logic [SND_W-1:0]   sender;
    logic [ADDR_W-1:0]  base;
    logic [LEN_W-1:0]   len;
    logic [ADDR_W-1:0]  addr;
  } desc_t;

  localparam int unsigned DESC_W = $bits(desc_t);

  typedef struct packed {
    status_e            status;
    logic [ADDR_W-1:0]  addr;
    logic [LEN_W-1:0]   len;
    logic [LEN_W-1:0]   dest;
    logic [SND_W-1:0]   sender;
    logic               rel_v;
    logic [ADDR_W-1:0]  rel_base;
    logic [LEN_W-1:0]   total;
    logic [LEN_W-1:0]   qval;
  } res_t;

  typedef struct packed {
    logic [CNT_W-1:0]   cnt;
    logic [LEN_W-1:0]   used;
  } stat_t;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
    if (i == IDX_W'(SEGS - 1)) return '0;
    return i + IDX_W'(1);
  endfunction

endpackage
`default_nettype wire

[design/sbq_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sbq_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module sbq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

[design/sbq_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sbq_front
// accepts requests, classifies them and holds them in a short queue
// ----------------------------------------------------------------------------
module sbq_front import sbq_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [ACT_W-1:0]     action_i,
  input  wire logic [IN_DATA_W-1:0] data_i,
  output logic                      cmd_valid_o,
  output cmd_t                      cmd_o,
  input  wire logic                 cmd_pop_i
);

  cmd_t              dec;
  cmd_t              q_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push;

  // classify the request
  always_comb begin
    dec.addr       = data_i[31:0];
    dec.base       = data_i[63:32];
    dec.len        = data_i[83:64];
    dec.sender     = data_i[132] ? data_i[131:84] : '0;
    dec.atomic     = data_i[133];
    dec.peek       = data_i[135];
    dec.remove_all = data_i[136];
    dec.offset     = data_i[156:137];
    dec.qkind      = data_i[158:157];
    dec.stopped    = data_i[159];
    case (action_e'(action_i))
      ACT_APPEND: dec.kind = K_APPEND;
      ACT_FETCH:  dec.kind = data_i[134] ? K_FETCH_STREAM : K_FETCH_RECORD;
      ACT_REMOVE: dec.kind = K_REMOVE;
      ACT_COPY:   dec.kind = K_COPY;
      ACT_QUERY:  dec.kind = K_QUERY;
      default:    dec.kind = K_BAD;
    endcase
  end

  assign in_ready_o  = (cnt_q != QCNT_W'(QDEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = q_q[rd_q];
  assign push        = in_valid_i && in_ready_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
    end
    if (cmd_pop_i) begin
      rd_d = (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
    end
    if (push && !cmd_pop_i) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (!push && cmd_pop_i) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_q] <= dec;
    end
  end

endmodule
`default_nettype wire

[design/sbq_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sbq_back
// owns the descriptor ring and carries out one request at a time
// ----------------------------------------------------------------------------
module sbq_back import sbq_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_valid_i,
  input  wire logic [LEN_W-1:0] cfg_data_i,
  input  wire logic             cmd_valid_i,
  input  wire cmd_t             cmd_i,
  output logic                  cmd_pop_o,
  output logic                  res_valid_o,
  output res_t                  res_o,
  output logic                  res_last_o,
  input  wire logic             res_ready_i,
  output stat_t                 stat_o
);

  state_e             state_q, state_d;
  logic [IDX_W-1:0]   head_q, head_d, tail_q, tail_d, ptr_q, ptr_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d, idx_q, idx_d;
  logic [LEN_W-1:0]   used_q, used_d, max_q;
  logic [LEN_W-1:0]   rem_q, rem_d, got_q, got_d, off_q, off_d;
  logic [RES_W-1:0]   n_q, n_d;
  kind_e              kind_q, kind_d;
  logic               peek_q, peek_d;
  res_t               pend_q, pend_d;
  logic               pend_v_q, pend_v_d;
  res_t               out_q;
  logic               out_last_q, out_v_q;

  logic               emit, emit_last, emit_ok;
  res_t               emit_res;
  logic               ram_we, ram_re;
  logic [IDX_W-1:0]   ram_waddr;
  desc_t              ram_wdata;
  logic [DESC_W-1:0]  ram_rdata;

  sbq_ram #(
    .WIDTH (DESC_W),
    .DEPTH (SEGS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ptr_q),
    .rdata_o (ram_rdata)
  );

  assign emit_ok     = !out_v_q || res_ready_i;
  assign res_valid_o = out_v_q;
  assign res_o       = out_q;
  assign res_last_o  = out_last_q;
  assign stat_o      = '{cnt: cnt_q, used: used_q};

  always_comb begin
    logic [LEN_W-1:0] freesp, amt, take, sl, cs;
    logic [ADDR_W-1:0] ca;
    logic [RES_W-1:0] nxt_n;
    logic go_on, start, skip;
    desc_t rd;

    state_d   = state_q;
    head_d    = head_q;
    tail_d    = tail_q;
    ptr_d     = ptr_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    used_d    = used_q;
    rem_d     = rem_q;
    got_d     = got_q;
    off_d     = off_q;
    n_d       = n_q;
    kind_d    = kind_q;
    peek_d    = peek_q;
    pend_d    = pend_q;
    pend_v_d  = pend_v_q;
    cmd_pop_o = 1'b0;
    emit      = 1'b0;
    emit_last = 1'b0;
    emit_res  = '0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = tail_q;
    ram_wdata = '0;
    go_on     = 1'b0;
    start     = 1'b0;
    skip      = 1'b0;
    take      = '0;
    cs        = '0;
    ca        = '0;
    rd        = desc_t'(ram_rdata);
    sl        = rd.len;
    nxt_n     = n_q + RES_W'(1);
    freesp    = (max_q > used_q) ? max_q - used_q : '0;
    amt       = cmd_i.remove_all ? used_q : cmd_i.len;

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && emit_ok) begin
          case (cmd_i.kind)
            K_APPEND: begin
              cmd_pop_o = 1'b1;
              emit      = 1'b1;
              emit_last = 1'b1;
              if (cnt_q >= CNT_W'(SEGS) ||
                  (cmd_i.len > freesp && (freesp == '0 || cmd_i.atomic))) begin
                emit_res.status = STS_BLOCK;
              end else begin
                if (cmd_i.len > freesp) begin
                  take            = freesp;
                  emit_res.status = STS_BLOCK;
                end else begin
                  take = cmd_i.len;
                end
                ram_we         = 1'b1;
                ram_wdata      = '{sender: cmd_i.sender, base: cmd_i.base,
                                   len: take, addr: cmd_i.addr};
                tail_d         = idx_inc(tail_q);
                cnt_d          = cnt_q + CNT_W'(1);
                used_d         = used_q + take;
                emit_res.total = take;
              end
            end
            K_QUERY: begin
              cmd_pop_o = 1'b1;
              emit      = 1'b1;
              emit_last = 1'b1;
              case (qkind_e'(cmd_i.qkind))
                QK_USED: emit_res.qval   = used_q;
                QK_FREE: emit_res.qval   = freesp;
                QK_MAX:  emit_res.qval   = max_q;
                default: emit_res.status = STS_ERR;
              endcase
            end
            K_FETCH_STREAM, K_FETCH_RECORD: begin
              if (cmd_i.len == '0 || cnt_q == '0) begin
                cmd_pop_o       = 1'b1;
                emit            = 1'b1;
                emit_last       = 1'b1;
                emit_res.status = (cmd_i.len != '0 && !cmd_i.stopped) ? STS_BLOCK : STS_OK;
              end else begin
                start = 1'b1;
              end
            end
            K_REMOVE: begin
              if (amt > used_q || cnt_q == '0) begin
                cmd_pop_o       = 1'b1;
                emit            = 1'b1;
                emit_last       = 1'b1;
                emit_res.status = (amt > used_q) ? STS_ERR : STS_OK;
              end else begin
                start = 1'b1;
              end
            end
            K_COPY: begin
              if (cnt_q == '0) begin
                cmd_pop_o = 1'b1;
                emit      = 1'b1;
                emit_last = 1'b1;
              end else begin
                start = 1'b1;
              end
            end
            default: begin
              cmd_pop_o       = 1'b1;
              emit            = 1'b1;
              emit_last       = 1'b1;
              emit_res.status = STS_ERR;
            end
          endcase
          if (start) begin
            cmd_pop_o = 1'b1;
            kind_d    = cmd_i.kind;
            peek_d    = cmd_i.peek;
            ptr_d     = head_q;
            idx_d     = '0;
            rem_d     = (cmd_i.kind == K_REMOVE) ? amt : cmd_i.len;
            got_d     = '0;
            off_d     = cmd_i.offset;
            n_d       = '0;
            pend_v_d  = 1'b0;
            state_d   = S_READ;
          end
        end
      end

      S_READ: begin
        ram_re  = 1'b1;
        state_d = S_EVAL;
      end

      S_EVAL: begin
        if (emit_ok) begin
          case (kind_q)
            K_FETCH_STREAM: begin
              emit          = 1'b1;
              emit_res.addr = rd.addr;
              emit_res.dest = got_q;
              n_d           = nxt_n;
              if (sl <= rem_q) begin
                emit_res.len   = sl;
                emit_res.total = got_q + sl;
                got_d          = got_q + sl;
                rem_d          = rem_q - sl;
                if (!peek_q) begin
                  emit_res.rel_v    = 1'b1;
                  emit_res.rel_base = rd.base;
                  used_d            = used_q - sl;
                  head_d            = idx_inc(head_q);
                  cnt_d             = cnt_q - CNT_W'(1);
                  ptr_d             = idx_inc(head_q);
                  go_on = (rem_q != sl) && (cnt_q > CNT_W'(1)) &&
                          (nxt_n < RES_W'(MAX_RES));
                end else begin
                  idx_d = idx_q + CNT_W'(1);
                  ptr_d = idx_inc(ptr_q);
                  go_on = (rem_q != sl) && ((idx_q + CNT_W'(1)) < cnt_q) &&
                          (nxt_n < RES_W'(MAX_RES));
                end
              end else begin
                emit_res.len   = rem_q;
                emit_res.total = got_q + rem_q;
                if (!peek_q) begin
                  used_d    = used_q - rem_q;
                  ram_we    = 1'b1;
                  ram_waddr = ptr_q;
                  ram_wdata = '{sender: rd.sender, base: rd.base, len: sl - rem_q,
                                addr: rd.addr + ADDR_W'(rem_q)};
                end
              end
              emit_last = !go_on;
              state_d   = go_on ? S_READ : S_IDLE;
            end

            K_FETCH_RECORD: begin
              emit            = 1'b1;
              emit_last       = 1'b1;
              cs              = (rem_q < sl) ? rem_q : sl;
              emit_res.addr   = rd.addr;
              emit_res.len    = cs;
              emit_res.sender = rd.sender;
              emit_res.total  = cs;
              if (!peek_q) begin
                emit_res.rel_v    = 1'b1;
                emit_res.rel_base = rd.base;
                used_d            = used_q - sl;
                head_d            = idx_inc(head_q);
                cnt_d             = cnt_q - CNT_W'(1);
              end
              state_d = S_IDLE;
            end

            K_REMOVE: begin
              if (rem_q >= sl) begin
                // hold the new release until the next step shows whether it is final
                if (pend_v_q) begin
                  emit     = 1'b1;
                  emit_res = pend_q;
                end
                pend_d          = '0;
                pend_d.rel_v    = 1'b1;
                pend_d.rel_base = rd.base;
                pend_d.total    = got_q + sl;
                pend_v_d        = 1'b1;
                n_d             = nxt_n;
                rem_d           = rem_q - sl;
                got_d           = got_q + sl;
                used_d          = used_q - sl;
                head_d          = idx_inc(head_q);
                cnt_d           = cnt_q - CNT_W'(1);
                ptr_d           = idx_inc(head_q);
                go_on = (rem_q != sl) && (cnt_q > CNT_W'(1)) &&
                        (nxt_n < RES_W'(MAX_RES));
                state_d = go_on ? S_READ : S_FLUSH;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = ptr_q;
                ram_wdata = '{sender: rd.sender, base: rd.base, len: sl - rem_q,
                              addr: rd.addr + ADDR_W'(rem_q)};
                used_d    = used_q - rem_q;
                emit      = 1'b1;
                emit_last = 1'b1;
                if (pend_v_q) begin
                  emit_res = pend_q;
                  pend_v_d = 1'b0;
                end else begin
                  emit_res.total = got_q + rem_q;
                end
                state_d = S_IDLE;
              end
            end

            K_COPY: begin
              ca = rd.addr;
              cs = sl;
              if (off_q != '0) begin
                if (off_q >= sl) begin
                  skip  = 1'b1;
                  off_d = off_q - sl;
                end else begin
                  ca    = rd.addr + ADDR_W'(off_q);
                  cs    = sl - off_q;
                  off_d = '0;
                end
              end
              idx_d = idx_q + CNT_W'(1);
              ptr_d = idx_inc(ptr_q);
              if (skip) begin
                // nothing found yet, so no piece has been reported
                if ((idx_q + CNT_W'(1)) < cnt_q) begin
                  state_d = S_READ;
                end else begin
                  emit      = 1'b1;
                  emit_last = 1'b1;
                  state_d   = S_IDLE;
                end
              end else begin
                if (cs > rem_q) begin
                  cs = rem_q;
                end
                emit           = 1'b1;
                emit_res.addr  = ca;
                emit_res.len   = cs;
                emit_res.dest  = got_q;
                emit_res.total = got_q + cs;
                got_d          = got_q + cs;
                rem_d          = rem_q - cs;
                n_d            = nxt_n;
                go_on = (rem_q != cs) && ((idx_q + CNT_W'(1)) < cnt_q) &&
                        (nxt_n < RES_W'(MAX_RES));
                emit_last = !go_on;
                state_d   = go_on ? S_READ : S_IDLE;
              end
            end

            default: state_d = S_IDLE;
          endcase
        end
      end

      S_FLUSH: begin
        if (emit_ok) begin
          emit      = 1'b1;
          emit_last = 1'b1;
          emit_res  = pend_q;
          pend_v_d  = 1'b0;
          state_d   = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      head_q   <= '0;
      tail_q   <= '0;
      cnt_q    <= '0;
      used_q   <= '0;
      max_q    <= MAX_SIZE_RST;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      cnt_q    <= cnt_d;
      used_q   <= used_d;
      pend_v_q <= pend_v_d;
      if (cfg_valid_i) begin
        max_q <= cfg_data_i;
      end
      if (emit) begin
        out_v_q <= 1'b1;
      end else if (res_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // walk registers and payload
  always_ff @(posedge clk_i) begin
    ptr_q  <= ptr_d;
    idx_q  <= idx_d;
    rem_q  <= rem_d;
    got_q  <= got_d;
    off_q  <= off_d;
    n_q    <= n_d;
    kind_q <= kind_d;
    peek_q <= peek_d;
    pend_q <= pend_d;
    if (emit) begin
      out_q      <= emit_res;
      out_last_q <= emit_last;
    end
  end

endmodule
`default_nettype wire

[design/socket_segment_buffer_queue_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// socket_segment_buffer_queue_core
// segment descriptor ring of one socket buffer with append, fetch, remove,
// copy and query requests
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                 payload
// s_axis    in         s_axis_tvalid/tready      tuser action, tdata fields
// m_axis    out        m_axis_tvalid/tready      tuser status, tdata, tlast
// cfg       in         cfg_valid/cfg_ready       cfg_data = max_size
//
// a request passes through the front queue and then the back;
// single-result requests (append, query, empty or failed ones) retire straight
// from idle, while walks read each descriptor and then evaluate it, since the
// descriptor ram has a registered read port
// reset clears the ring pointers and counts and sets the capacity to 4096, no sweep
// the front keeps accepting until its two-entry queue fills while the back
// waits on m_axis_tready; results leave through one output register
//
module socket_segment_buffer_queue_core import sbq_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // tdata: seg_addr, seg_base, length, sender_addr, has_sender, atomic,
  //        fetch_flags, remove_all, offset, query_kind, recv_stopped
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: action
  input  wire logic [ACT_W-1:0]      s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // tdata: piece_addr, piece_len, dest_offset, piece_sender, release_valid,
  //        release_base, total_amount, query_value, zero fill
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  // tuser: status
  output logic [1:0]                 m_axis_tuser,
  output logic                       m_axis_tlast,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [LEN_W-1:0]      cfg_data
);

  logic  cmd_valid, cmd_pop;
  cmd_t  cmd;
  res_t  res;
  stat_t stat;

  // capacity writes are always taken
  assign cfg_ready = 1'b1;

  sbq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .action_i    (s_axis_tuser),
    .data_i      (s_axis_tdata),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  sbq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_data_i  (cfg_data),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_valid_o (m_axis_tvalid),
    .res_o       (res),
    .res_last_o  (m_axis_tlast),
    .res_ready_i (m_axis_tready),
    .stat_o      (stat)
  );

  // result packing, lowest field first
  assign m_axis_tdata = {7'b0, res.qval, res.total, res.rel_base, res.rel_v,
                         res.sender, res.dest, res.len, res.addr};
  assign m_axis_tuser = res.status;

`ifndef SYNTHESIS
  // ring never holds more descriptors than it has slots
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.cnt <= CNT_W'(SEGS))
    else $error("segment count beyond ring size");

  // an empty ring holds no bytes
  a_empty_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.cnt == '0 |-> stat.used == '0)
    else $error("bytes counted with no segments");

  // a released segment only comes with a successful result
  a_rel_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res.rel_v) |-> m_axis_tuser == STS_OK)
    else $error("release on a failed result");
`endif

endmodule
`default_nettype wire
